FILE: hdl/isort_pkg.sv
// Shared types for the insertion sorter cell chain.
`timescale 1ns / 1ps
`default_nettype none
package isort_pkg;

    localparam int unsigned SAMPLE_W = 32;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;     // place the broadcast value in its ordered slot
        logic shift_out;  // advance every entry one cell toward the head
    } t_cell_ctrl;

endpackage
`default_nettype wire

FILE: hdl/isort_cell.sv
// One storage cell of the sorting chain: holds one entry and its occupancy bit.
`timescale 1ns / 1ps
`default_nettype none
module isort_cell (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire isort_pkg::t_cell_ctrl i_ctrl,
    input  wire isort_pkg::t_sample   i_new_value,
    input  wire isort_pkg::t_sample   i_left_value,
    input  wire logic                 i_left_valid,
    input  wire logic                 i_left_gt,
    input  wire isort_pkg::t_sample   i_right_value,
    input  wire logic                 i_right_valid,
    output      isort_pkg::t_sample   o_value,
    output      logic                 o_valid,
    output      logic                 o_gt
);
    import isort_pkg::*;

    t_sample r_value;
    t_sample n_value;
    logic    r_valid;
    logic    n_valid;

    // Strictly greater keeps equal values in arrival order.
    assign o_gt    = r_valid && (r_value > i_new_value);
    assign o_value = r_value;
    assign o_valid = r_valid;

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctrl.shift_out) begin
            n_value = i_right_value;
            n_valid = i_right_valid;
        end else if (i_ctrl.insert) begin
            if (o_gt || !r_valid) begin
                n_value = i_left_gt ? i_left_value : i_new_value;
            end
            n_valid = r_valid || i_left_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/insertion_sorter_core.sv
// Top level of the streaming insertion sorter built on a chain of cells.
//
// Input channel (i_valid / o_ready): one signed 32-bit sample per transaction;
// i_end_of_set marks the last sample of a set. Every cell compares the
// sample with its entry in parallel and the chain opens a slot without a
// stall, so samples are taken one per cycle while a set is being collected.
// Once the chain holds CAPACITY entries, further samples are dropped and the
// overflow flag is raised for the set.
// Output channel (o_valid / i_ready): after the ending transaction the chain
// drains in ascending order from the head cell, one result per cycle while
// i_ready is high, the first appearing the cycle after the ending sample is
// taken. A set of N stored entries takes N result transactions; the final
// one is marked by o_final_result, and o_overflow_seen is high on all of
// them if a sample was dropped. The input is held off (o_ready low) while
// the chain drains. When the receiver stalls, the head entry simply holds
// on the output and nothing advances. Reset empties the chain and clears
// the overflow flag; no clearing pass is needed since each cell carries
// its own occupancy bit.
`timescale 1ns / 1ps
`default_nettype none
module insertion_sorter_core #(
    parameter int unsigned CAPACITY = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire isort_pkg::t_sample i_sample_value,
    input  wire logic               i_end_of_set,
    input  wire logic               i_valid,
    output      logic               o_ready,
    output      isort_pkg::t_sample o_sorted_value,
    output      logic               o_final_result,
    output      logic               o_overflow_seen,
    output      logic               o_valid,
    input  wire logic               i_ready
);
    import isort_pkg::*;

    // Chain taps: occupancy, stored values and per-cell compare results.
    t_sample                w_value [CAPACITY];
    logic    [CAPACITY-1:0] w_valid;
    logic    [CAPACITY-1:0] w_gt;

    logic       r_draining;
    logic       n_draining;
    logic       r_dropped;
    logic       n_dropped;
    logic       w_in_fire;
    logic       w_out_fire;
    logic       w_full;
    t_cell_ctrl w_ctrl;

    // Occupancy is a thermometer from the head, so the tail bit means full.
    assign w_full     = w_valid[CAPACITY-1];
    assign w_in_fire  = i_valid && o_ready;
    assign w_out_fire = o_valid && i_ready;

    assign w_ctrl.insert    = w_in_fire && !w_full;
    assign w_ctrl.shift_out = w_out_fire;

    // Result comes straight off the head cell; the next cell tells whether
    // this is the last entry of the run.
    assign o_ready         = !r_draining;
    assign o_valid         = r_draining && w_valid[0];
    assign o_sorted_value  = w_value[0];
    assign o_final_result  = !w_valid[1];
    assign o_overflow_seen = r_dropped;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_sample w_left_value;
        logic    w_left_valid;
        logic    w_left_gt;
        t_sample w_right_value;
        logic    w_right_valid;

        if (g == 0) begin : g_head
            // Head has an always-occupied, never-greater neighbor on its left.
            assign w_left_value = i_sample_value;
            assign w_left_valid = 1'b1;
            assign w_left_gt    = 1'b0;
        end else begin : g_body
            assign w_left_value = w_value[g-1];
            assign w_left_valid = w_valid[g-1];
            assign w_left_gt    = w_gt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right_value = '0;
            assign w_right_valid = 1'b0;
        end else begin : g_inner
            assign w_right_value = w_value[g+1];
            assign w_right_valid = w_valid[g+1];
        end

        isort_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_new_value   (i_sample_value),
            .i_left_value  (w_left_value),
            .i_left_valid  (w_left_valid),
            .i_left_gt     (w_left_gt),
            .i_right_value (w_right_value),
            .i_right_valid (w_right_valid),
            .o_value       (w_value[g]),
            .o_valid       (w_valid[g]),
            .o_gt          (w_gt[g])
        );
    end

    // Drain and overflow control: start on the ending transaction, stop on the final result.
    always_comb begin
        n_draining = r_draining;
        n_dropped  = r_dropped;
        if (w_in_fire) begin
            if (w_full) begin
                n_dropped = 1'b1;
            end
            if (i_end_of_set) begin
                n_draining = 1'b1;
            end
        end
        if (w_out_fire && o_final_result) begin
            n_draining = 1'b0;
            n_dropped  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draining <= 1'b0;
            r_dropped  <= 1'b0;
        end else begin
            r_draining <= n_draining;
            r_dropped  <= n_dropped;
        end
    end

`ifndef NO_ASSERTIONS
    // Occupied cells always form a contiguous run from the head.
    a_thermometer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + {{(CAPACITY-1){1'b0}}, 1'b1})) == '0)
        else $error("chain occupancy is not contiguous");

    // The final result empties the whole chain.
    a_final_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_fire && o_final_result) |=> (w_valid == '0))
        else $error("entries left behind after the final result");

    // A drain never starts on an empty chain.
    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_end_of_set) |=> o_valid)
        else $error("drain started with no entry stored");

    // A sample arriving at a full chain raises the overflow flag.
    a_drop_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && w_full) |=> r_dropped)
        else $error("dropped sample did not set the overflow flag");
`endif

endmodule
`default_nettype wire
